[hdl/nnsa_pkg.sv]
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared widths, register indices and pipeline sideband for the NV12
// nearest-neighbour address generator.
// ----------------------------------------------------------------------------
package nnsa_pkg;

    localparam int DIM_W   = 13;   // frame dimension registers
    localparam int COORD_W = 12;   // destination row / byte column
    localparam int LEN_W   = 25;   // captured length
    localparam int OFF_W   = 25;   // byte offsets
    localparam int AREA_W  = 26;   // width * height product
    localparam int IDX_W   = 3;    // configuration register index

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH       = 3'd0,
        REG_SRC_HEIGHT      = 3'd1,
        REG_DST_WIDTH       = 3'd2,
        REG_DST_HEIGHT      = 3'd3,
        REG_CAPTURED_LENGTH = 3'd4
    } reg_idx_t;

    // Travels alongside the quotient pipelines
    typedef struct packed {
        logic               ok;      // dimensions and coordinate in range
        logic               chroma;  // interleaved U/V plane
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [AREA_W-1:0]  area;    // src_width * src_height
        logic [OFF_W-1:0]   dbase;   // dst_width * dst_height, low bits
    } sb_t;

endpackage

[hdl/nv12_nearest_scale_addr.sv]
// ----------------------------------------------------------------------------
// nv12_nearest_scale_addr
// Throughput: one transaction per clock when the output is not stalled.
// Pipeline: range checks and products, the two quotient pipelines that
// resolve one bit per stage, a length check, then the output register.
// Reset: asynchronous, active low; clears valid bits and loads register
// defaults (1920 x 1080 destination, no source).
// ----------------------------------------------------------------------------
module nv12_nearest_scale_addr
    import nnsa_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,

    // configuration write port
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [LEN_W-1:0]   cfg_data,

    // input channel: one destination byte
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               plane,
    input  logic [COORD_W-1:0] dst_row,
    input  logic [COORD_W-1:0] dst_col,

    // output channel: source and destination offsets
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OFF_W-1:0]   src_offset,
    output logic [OFF_W-1:0]   dst_offset,
    output logic               valid_res
);

    // Stage map: 0 = range checks and products, 1..QW = quotient bits,
    // QW+1 = length check and row products, QW+2 = offset sums (output).
    localparam int QW    = $clog2(MAX_DIM);
    localparam int NS    = QW + 3;
    localparam int NUM_W = COORD_W + DIM_W;
    localparam logic [DIM_W:0] MAX_DIM_V = (DIM_W + 1)'(MAX_DIM);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while no
    // transaction is in flight (not enforced here), so every stage may read them directly.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] src_width_reg;
    logic [DIM_W-1:0] src_height_reg;
    logic [DIM_W-1:0] dst_width_reg;
    logic [DIM_W-1:0] dst_height_reg;
    logic [LEN_W-1:0] captured_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg       <= '0;
            src_height_reg      <= '0;
            dst_width_reg       <= DIM_W'(1920);
            dst_height_reg      <= DIM_W'(1080);
            captured_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SRC_WIDTH:       src_width_reg       <= cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:      src_height_reg      <= cfg_data[DIM_W-1:0];
                REG_DST_WIDTH:       dst_width_reg       <= cfg_data[DIM_W-1:0];
                REG_DST_HEIGHT:      dst_height_reg      <= cfg_data[DIM_W-1:0];
                REG_CAPTURED_LENGTH: captured_length_reg <= cfg_data;
                default:             ;   // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain. A stage loads when it is empty or when the stage after
    // it moves, so bubbles collapse and the input keeps flowing while a
    // result waits in the output register.
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    assign en[NS-1] = !v_reg[NS-1] || !out_stall;

    genvar i;
    generate
        for (i = 0; i < NS - 1; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= in_valid;
        end
    end

    generate
        for (i = 1; i < NS; i++)
        begin : g_valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    endgenerate

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: frame checks, coordinate range, dividends and divisors.
    // Chroma works on halved sizes and the U/V pair index col/2.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   csw;
    logic [DIM_W-1:0]   csh;
    logic [DIM_W-1:0]   cdw;
    logic [DIM_W-1:0]   cdh;
    logic [COORD_W-2:0] cx;
    logic               dim_ok;
    logic               luma_in;
    logic               chroma_in;
    logic [DIM_W-1:0]   rmul;
    logic [DIM_W-1:0]   cmul;
    logic [COORD_W-1:0] cop;
    logic [AREA_W-1:0]  dprod;
    sb_t                s0_sb;

    assign csw = src_width_reg  >> 1;
    assign csh = src_height_reg >> 1;
    assign cdw = dst_width_reg  >> 1;
    assign cdh = dst_height_reg >> 1;
    assign cx  = dst_col[COORD_W-1:1];

    assign dim_ok = (src_width_reg  != '0) && (src_height_reg != '0) &&
                    (dst_width_reg  != '0) && (dst_height_reg != '0) &&
                    ({1'b0, src_width_reg}  <= MAX_DIM_V) &&
                    ({1'b0, src_height_reg} <= MAX_DIM_V) &&
                    ({1'b0, dst_width_reg}  <= MAX_DIM_V) &&
                    ({1'b0, dst_height_reg} <= MAX_DIM_V);

    assign luma_in   = ({1'b0, dst_row} < dst_height_reg) &&
                       ({1'b0, dst_col} < dst_width_reg);
    // a destination of height or width one has no chroma bytes
    assign chroma_in = (cdh != '0) && (cdw != '0) &&
                       ({1'b0, dst_row} < cdh) && ({2'b0, cx} < cdw);

    assign rmul  = plane ? csh : src_height_reg;
    assign cmul  = plane ? csw : src_width_reg;
    assign cop   = plane ? {1'b0, cx} : dst_col;
    assign dprod = AREA_W'(dst_width_reg) * AREA_W'(dst_height_reg);

    always_comb
    begin
        s0_sb.ok     = dim_ok && (plane ? chroma_in : luma_in);
        s0_sb.chroma = plane;
        s0_sb.row    = dst_row;
        s0_sb.col    = dst_col;
        s0_sb.area   = AREA_W'(src_width_reg) * AREA_W'(src_height_reg);
        s0_sb.dbase  = dprod[OFF_W-1:0];
    end

    sb_t              s0_sb_reg;
    logic [NUM_W-1:0] num_r_reg;
    logic [NUM_W-1:0] num_c_reg;
    logic [DIM_W-1:0] den_r_reg;
    logic [DIM_W-1:0] den_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_sb_reg <= s0_sb;
            num_r_reg <= NUM_W'(dst_row) * NUM_W'(rmul);
            num_c_reg <= NUM_W'(cop) * NUM_W'(cmul);
            den_r_reg <= plane ? cdh : dst_height_reg;
            den_c_reg <= plane ? cdw : dst_width_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..QW: source row and column quotients, sideband in step.
    // ------------------------------------------------------------------
    logic [QW-1:0] q_row;
    logic [QW-1:0] q_col;
    sb_t           sb_reg [QW];

    nnsa_div #(
        .QW    (QW),
        .NUM_W (NUM_W)
    ) u_div_row (
        .clk (clk),
        .en  (en[QW:1]),
        .num (num_r_reg),
        .den (den_r_reg),
        .quo (q_row)
    );

    nnsa_div #(
        .QW    (QW),
        .NUM_W (NUM_W)
    ) u_div_col (
        .clk (clk),
        .en  (en[QW:1]),
        .num (num_c_reg),
        .den (den_c_reg),
        .quo (q_col)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sb_reg[0] <= s0_sb_reg;
        end
    end

    generate
        for (i = 1; i < QW; i++)
        begin : g_sb
            always_ff @(posedge clk)
            begin
                if (en[i+1])
                begin
                    sb_reg[i] <= sb_reg[i-1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage QW+1: captured length against 3/2 of the source area, source
    // row base and destination row base.
    // ------------------------------------------------------------------
    sb_t               sbq;
    logic [AREA_W:0]   need;
    logic [AREA_W-1:0] qrsw;
    logic [AREA_W-1:0] rdw;

    assign sbq  = sb_reg[QW-1];
    assign need = {1'b0, sbq.area} + {2'b0, sbq.area[AREA_W-1:1]};
    assign qrsw = AREA_W'(q_row) * AREA_W'(src_width_reg);
    assign rdw  = AREA_W'(sbq.row) * AREA_W'(dst_width_reg);

    logic               f1_ok_reg;
    logic               f1_chroma_reg;
    logic [COORD_W-1:0] f1_col_reg;
    logic [QW-1:0]      f1_qcol_reg;
    logic [OFF_W-1:0]   f1_qrsw_reg;
    logic [OFF_W-1:0]   f1_rdw_reg;
    logic [OFF_W-1:0]   f1_area_reg;
    logic [OFF_W-1:0]   f1_dbase_reg;

    always_ff @(posedge clk)
    begin
        if (en[QW+1])
        begin
            f1_ok_reg     <= sbq.ok && ({2'b0, captured_length_reg} >= need);
            f1_chroma_reg <= sbq.chroma;
            f1_col_reg    <= sbq.col;
            f1_qcol_reg   <= q_col;
            f1_qrsw_reg   <= qrsw[OFF_W-1:0];
            f1_rdw_reg    <= rdw[OFF_W-1:0];
            f1_area_reg   <= sbq.area[OFF_W-1:0];
            f1_dbase_reg  <= sbq.dbase;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: offset sums, forced to zero for a refused copy.
    // Chroma sits after the luma plane; col keeps the U/V parity.
    // ------------------------------------------------------------------
    logic [OFF_W-1:0] so_sum;
    logic [OFF_W-1:0] do_sum;

    assign so_sum = f1_chroma_reg
                  ? f1_area_reg + f1_qrsw_reg + OFF_W'({f1_qcol_reg, f1_col_reg[0]})
                  : f1_qrsw_reg + OFF_W'(f1_qcol_reg);
    assign do_sum = (f1_chroma_reg ? f1_dbase_reg : '0) + f1_rdw_reg
                  + OFF_W'(f1_col_reg);

    logic [OFF_W-1:0] src_offset_reg;
    logic [OFF_W-1:0] dst_offset_reg;
    logic             valid_res_reg;

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            src_offset_reg <= f1_ok_reg ? so_sum : '0;
            dst_offset_reg <= f1_ok_reg ? do_sum : '0;
            valid_res_reg  <= f1_ok_reg;
        end
    end

    assign src_offset = src_offset_reg;
    assign dst_offset = dst_offset_reg;
    assign valid_res  = valid_res_reg;

endmodule

[hdl/nnsa_div.sv]
// ----------------------------------------------------------------------------
// nnsa_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// only meaningful when it fits in QW bits.
// ----------------------------------------------------------------------------
module nnsa_div
    import nnsa_pkg::*;
#(
    parameter int QW    = 12,
    parameter int NUM_W = 25
)
(
    input  logic              clk,
    input  logic [QW-1:0]     en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DIM_W-1:0]  den,
    output logic [QW-1:0]     quo
);

    localparam int CW = NUM_W + QW;

    logic [NUM_W-1:0] rem_reg [QW-1];
    logic [DIM_W-1:0] den_reg [QW-1];
    logic [QW-1:0]    quo_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int            SH  = QW - 1 - k;
            localparam logic [QW-1:0] BIT = QW'(1) << SH;

            logic [NUM_W-1:0] rem_in;
            logic [DIM_W-1:0] den_in;
            logic [QW-1:0]    quo_in;
            logic [CW-1:0]    dsh;
            logic [CW-1:0]    diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            assign dsh  = CW'(den_in) << SH;
            assign ge   = CW'(rem_in) >= dsh;
            assign diff = CW'(rem_in) - dsh;

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    quo_reg[k] <= ge ? (quo_in | BIT) : quo_in;
                end
            end

            // last stage needs no remainder or divisor
            if (k < QW - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en[k])
                    begin
                        rem_reg[k] <= ge ? diff[NUM_W-1:0] : rem_in;
                        den_reg[k] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

[hdl/nnsa_chk.sv]
// ----------------------------------------------------------------------------
// nnsa_chk
// Port-level checks for the NV12 address generator, bound to the top level.
// ----------------------------------------------------------------------------
module nnsa_chk
    import nnsa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [OFF_W-1:0] src_offset,
    input logic [OFF_W-1:0] dst_offset,
    input logic             valid_res
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(src_offset) &&
        $stable(dst_offset) && $stable(valid_res))
        else $error("result changed while stalled");

    // a refused copy carries zero offsets
    a_zero_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> src_offset == '0 && dst_offset == '0)
        else $error("refused transaction with non-zero offset");

    // back-pressure only when the whole pipe is full behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // nothing emitted and input not stalled while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("activity during reset");

endmodule

bind nv12_nearest_scale_addr nnsa_chk u_nnsa_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .src_offset (src_offset),
    .dst_offset (dst_offset),
    .valid_res  (valid_res)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NV12 nearest-neighbour address generator.
// Each destination byte sent in is mapped by a local predictor to its
// expected source/destination offsets and valid flag; every result
// transaction is compared field by field with the oldest expectation.
// Directed cases cover defaults, range edges, short capture, register
// masking and sizes at the limits. Random traffic then runs under several
// idle/stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb
    import nnsa_pkg::*;
();

    localparam int MAX_DIM = 4096;
    localparam int LATENCY = $clog2(MAX_DIM) + 3;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;   // no register here
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef struct packed {
        logic [OFF_W-1:0] src_off;
        logic [OFF_W-1:0] dst_off;
        logic             ok;
    } offsets_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [LEN_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               plane;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
    logic               out_valid;
    logic               out_stall;
    logic [OFF_W-1:0]   src_offset;
    logic [OFF_W-1:0]   dst_offset;
    logic               valid_res;

    // Local copy of the register file, kept in step with every write
    logic [DIM_W-1:0]   src_w, src_h, dst_w, dst_h;
    logic [LEN_W-1:0]   cap_len;

    offsets_t           pending_offsets[$];
    int                 mismatches = 0;
    int                 idle_pct   = 0;   // sender: chance of a gap per cycle
    int                 stall_pct  = 0;   // receiver: chance of a stall per cycle
    int                 hold_left  = 0;   // receiver: cycles of forced stall left

    nv12_nearest_scale_addr #(.MAX_DIM(MAX_DIM)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plane      (plane),
        .dst_row    (dst_row),
        .dst_col    (dst_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .src_offset (src_offset),
        .dst_offset (dst_offset),
        .valid_res  (valid_res)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: nearest-neighbour mapping of one destination byte.
    // Luma scales row and column directly; chroma works on U/V pairs at
    // half size and keeps the byte parity (U even, V odd). Any failed
    // check forces both offsets to zero.
    // ------------------------------------------------------------------
    function automatic offsets_t map_byte(input logic pl,
                                          input logic [COORD_W-1:0] r,
                                          input logic [COORD_W-1:0] c);
        bit [63:0] sw, sh, dw, dh, row, col, cx, need, so, dof;
        bit        ok;
        offsets_t  res;
        sw  = 64'(src_w);
        sh  = 64'(src_h);
        dw  = 64'(dst_w);
        dh  = 64'(dst_h);
        row = 64'(r);
        col = 64'(c);
        so  = 0;
        dof = 0;
        ok  = sw != 0 && sh != 0 && dw != 0 && dh != 0
              && sw <= MAX_DIM && sh <= MAX_DIM && dw <= MAX_DIM && dh <= MAX_DIM;
        need = (sw * sh * 3) / 2;
        if (ok && cap_len < need)
            ok = 1'b0;
        if (ok && !pl)
        begin
            if (row >= dh || col >= dw)
                ok = 1'b0;
            else
            begin
                so  = ((row * sh) / dh) * sw + (col * sw) / dw;
                dof = row * dw + col;
            end
        end
        else if (ok)
        begin
            cx = col >> 1;
            // a destination one pixel wide or high has no chroma at all
            if (dw / 2 == 0 || dh / 2 == 0 || row >= dh / 2 || cx >= dw / 2)
                ok = 1'b0;
            else
            begin
                so  = sw * sh + ((row * (sh / 2)) / (dh / 2)) * sw
                      + ((cx * (sw / 2)) / (dw / 2)) * 2 + col[0];
                dof = dw * dh + row * dw + cx * 2 + col[0];
            end
        end
        if (!ok)
        begin
            so  = 0;
            dof = 0;
        end
        res.src_off = so[OFF_W-1:0];
        res.dst_off = dof[OFF_W-1:0];
        res.ok      = ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input bit [63:0] want,
                                   input bit [63:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every transaction on the output channel is popped
    // against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        offsets_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_offsets.size() == 0)
                report_mismatch("unexpected transaction, src_offset", 0, src_offset);
            else
            begin
                want = pending_offsets.pop_front();
                if (src_offset !== want.src_off)
                    report_mismatch("src_offset", want.src_off, src_offset);
                if (dst_offset !== want.dst_off)
                    report_mismatch("dst_offset", want.dst_off, dst_offset);
                if (valid_res !== want.ok)
                    report_mismatch("valid_res", want.ok, valid_res);
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Register write; only issued while nothing is in flight
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:       src_w   = data[DIM_W-1:0];
            REG_SRC_HEIGHT:      src_h   = data[DIM_W-1:0];
            REG_DST_WIDTH:       dst_w   = data[DIM_W-1:0];
            REG_DST_HEIGHT:      dst_h   = data[DIM_W-1:0];
            REG_CAPTURED_LENGTH: cap_len = data;
            default: ;
        endcase
    endtask

    // Write all five registers; dimension words carry junk above bit 12
    task automatic write_setting(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                 input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                                 input logic [LEN_W-1:0] len);
        write_reg(REG_SRC_WIDTH,  {(LEN_W-DIM_W)'($urandom), sw});
        write_reg(REG_SRC_HEIGHT, {(LEN_W-DIM_W)'($urandom), sh});
        write_reg(REG_DST_WIDTH,  {(LEN_W-DIM_W)'($urandom), dw});
        write_reg(REG_DST_HEIGHT, {(LEN_W-DIM_W)'($urandom), dh});
        write_reg(REG_CAPTURED_LENGTH, len);
    endtask

    // One transaction on the input channel, with random gaps ahead of it
    task automatic send_byte(input logic pl, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        plane    <= pl;
        dst_row  <= r;
        dst_col  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_offsets.push_back(map_byte(pl, r, c));
    endtask

    // Wait for every expected result, then let the pipeline run dry
    task automatic drain();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_offsets.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_offsets.size() != 0)
        begin
            report_mismatch("results never returned, count", 0, pending_offsets.size());
            pending_offsets.delete();
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Mostly in-range coordinates for the current destination size, some noise
    task automatic send_random_byte();
        logic pl;
        int   lim_r, lim_c;
        pl    = 1'($urandom_range(1));
        lim_r = pl ? int'(dst_h) / 2 : int'(dst_h);
        lim_c = pl ? (int'(dst_w) / 2) * 2 : int'(dst_w);
        if (lim_r > MAX_DIM)
            lim_r = MAX_DIM;
        if (lim_c > MAX_DIM)
            lim_c = MAX_DIM;
        if ($urandom_range(9) == 0 || lim_r == 0 || lim_c == 0)
            send_byte(pl, COORD_W'($urandom), COORD_W'($urandom));
        else
            send_byte(pl, COORD_W'($urandom_range(lim_r - 1)),
                      COORD_W'($urandom_range(lim_c - 1)));
    endtask

    // A random register setting: mostly usable, some broken on purpose
    task automatic random_setting();
        logic [DIM_W-1:0] sw, sh, dw, dh;
        logic [LEN_W-1:0] len;
        bit [63:0]        need;
        int               kind;
        kind = $urandom_range(11);
        sw = DIM_W'($urandom_range(1, MAX_DIM));
        sh = DIM_W'($urandom_range(1, MAX_DIM));
        dw = DIM_W'($urandom_range(1, MAX_DIM));
        dh = DIM_W'($urandom_range(1, MAX_DIM));
        case (kind)
            0:
            begin
                sw = DIM_W'(MAX_DIM);
                sh = DIM_W'(MAX_DIM);
                dw = DIM_W'(MAX_DIM);
                dh = DIM_W'(MAX_DIM);
            end
            1:
            begin
                sw = DIM_W'($urandom_range(1, 9));
                sh = DIM_W'($urandom_range(1, 9));
                dw = DIM_W'($urandom_range(1, 9));
                dh = DIM_W'($urandom_range(1, 9));
            end
            2:
            begin
                // one dimension zeroed: no source, or empty destination
                case ($urandom_range(3))
                    0: sw = '0;
                    1: sh = '0;
                    2: dw = '0;
                    default: dh = '0;
                endcase
            end
            3:
            begin
                // one dimension beyond the supported maximum
                case ($urandom_range(3))
                    0: sw = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
                    1: sh = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
                    2: dw = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
                    default: dh = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
                endcase
            end
            default: ;
        endcase
        need = (sw * sh * 3) / 2;
        if (need > LEN_MAX)
            len = LEN_MAX;
        else if (kind == 4 && need > 0)
            len = LEN_W'(need - 1);                  // capture one byte short
        else if ($urandom_range(1))
            len = need[LEN_W-1:0];
        else if (need + 1000000 > LEN_MAX)
            len = LEN_MAX;
        else
            len = LEN_W'(need + $urandom_range(1000000));
        write_setting(sw, sh, dw, dh, len);
        if ($urandom_range(3) == 0)
            write_reg(REG_UNMAPPED, LEN_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset there is no source; the 1920 x 1080 destination stays
    // in force until written
    task automatic test_reset_defaults();
        send_byte(1'b0, 12'd0, 12'd0);
        send_byte(1'b1, 12'd0, 12'd1);
        drain();
        write_reg(REG_SRC_WIDTH, 25'd640);
        write_reg(REG_SRC_HEIGHT, 25'd480);
        write_reg(REG_CAPTURED_LENGTH, 25'd460800);
        send_byte(1'b0, 12'd1079, 12'd1919);
        send_byte(1'b0, 12'd1080, 12'd0);
        drain();
    endtask

    // Corners of both planes, one past the luma column edge and each chroma edge
    task automatic test_plane_edges();
        write_setting(13'd640, 13'd480, 13'd1920, 13'd1080, 25'd460800);
        send_byte(1'b0, 12'd0, 12'd0);
        send_byte(1'b0, 12'd1079, 12'd1919);
        send_byte(1'b0, 12'd0, 12'd1920);
        send_byte(1'b1, 12'd0, 12'd0);
        send_byte(1'b1, 12'd0, 12'd1);
        send_byte(1'b1, 12'd539, 12'd1919);
        send_byte(1'b1, 12'd540, 12'd0);
        send_byte(1'b1, 12'd0, 12'd1920);
        drain();
    endtask

    // Capture length one below and exactly at the required size
    task automatic test_short_capture();
        write_reg(REG_CAPTURED_LENGTH, 25'd460799);
        send_byte(1'b0, 12'd5, 12'd7);
        drain();
        write_reg(REG_CAPTURED_LENGTH, 25'd460800);
        send_byte(1'b0, 12'd5, 12'd7);
        drain();
    endtask

    // High data bits dropped, unmapped index ignored, degenerate sizes
    task automatic test_register_edges();
        write_reg(REG_SRC_WIDTH, {12'hFFF, 13'd320});
        write_reg(REG_UNMAPPED, LEN_MAX);
        send_byte(1'b0, 12'd100, 12'd200);
        drain();
        write_setting(13'd2, 13'd2, 13'd1, 13'd1, 25'd6);    // no chroma at 1 x 1
        send_byte(1'b0, 12'd0, 12'd0);
        send_byte(1'b1, 12'd0, 12'd0);
        drain();
        write_setting(13'd640, 13'd480, 13'd4097, 13'd1080, LEN_MAX);
        send_byte(1'b0, 12'd0, 12'd0);
        drain();
        write_setting(13'd640, 13'd480, 13'd0, 13'd1080, LEN_MAX);
        send_byte(1'b0, 12'd0, 12'd0);
        drain();
    endtask

    // Everything at the maximum: largest offsets the block can produce
    task automatic test_full_size();
        write_setting(13'd4096, 13'd4096, 13'd4096, 13'd4096, LEN_MAX);
        send_byte(1'b0, 12'd4095, 12'd4095);
        send_byte(1'b1, 12'd2047, 12'd4095);
        send_byte(1'b1, 12'd2047, 12'd4094);
        drain();
    endtask

    // Random settings and traffic under four idle/stall mixes
    task automatic test_random_traffic();
        int mix, s, i;
        for (mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (s = 0; s < 5; s++)
            begin
                random_setting();
                for (i = 0; i < 70; i++)
                    send_random_byte();
                drain();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // Output held off long enough for the pipeline to fill and push back
    task automatic test_backpressure();
        int i;
        write_setting(13'd1280, 13'd720, 13'd1920, 13'd1080, 25'd1382400);
        @(posedge clk);
        hold_left = 300;
        for (i = 0; i < 60; i++)
            send_random_byte();
        drain();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        plane     = 1'b0;
        dst_row   = '0;
        dst_col   = '0;
        out_stall = 1'b0;
        src_w     = 13'd0;
        src_h     = 13'd0;
        dst_w     = 13'd1920;
        dst_h     = 13'd1080;
        cap_len   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_plane_edges();
        test_short_capture();
        test_register_edges();
        test_full_size();
        test_random_traffic();
        test_backpressure();

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/nnsa_pkg.sv
hdl/nnsa_div.sv
hdl/nv12_nearest_scale_addr.sv
hdl/nnsa_chk.sv
tb/tb.sv
